@@ rtl/lpcrc_pkg.sv @@
// Shared definitions for the link-packet CRC-32K generator.
// Holds the item operation codes and the CRC constants; no dependencies.

package lpcrc_pkg;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_DATA   = 2'd1,
    OP_TAIL   = 2'd2
  } op_t;

  localparam int unsigned CRC_WIDTH   = 32;
  localparam int unsigned WORD_WIDTH  = 64;
  localparam int unsigned BYTE_WIDTH  = 8;
  localparam int unsigned CELL_COUNT  = WORD_WIDTH / BYTE_WIDTH;

  localparam logic [CRC_WIDTH-1:0] CRC_POLY = 32'hEB31D82E;
  localparam logic [CRC_WIDTH-1:0] CRC_INIT = 32'hFFFFFFFF;

  typedef logic [CRC_WIDTH-1:0]  crc_t;
  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [BYTE_WIDTH-1:0] byte_t;

endpackage

@@ rtl/lpcrc_if.sv @@
// Valid/ready channel interfaces for packet words in and CRC results out.
// Depends on lpcrc_pkg.

interface lpcrc_item_if;
  import lpcrc_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic        is_response;
  logic [2:0]  cube_id;
  logic [63:0] word_value;
  logic [10:0] packet_tag;
  logic [4:0]  flit_length;
  logic [6:0]  command_code;
  logic [2:0]  source_link;
  logic        flag_bit;
  logic [2:0]  retry_count;
  logic [6:0]  error_status;
  logic [20:0] pointers;

  modport source (
    output valid, operation, is_response, cube_id, word_value, packet_tag,
           flit_length, command_code, source_link, flag_bit, retry_count,
           error_status, pointers,
    input  ready
  );

  modport sink (
    input  valid, operation, is_response, cube_id, word_value, packet_tag,
           flit_length, command_code, source_link, flag_bit, retry_count,
           error_status, pointers,
    output ready
  );
endinterface

interface lpcrc_result_if;
  import lpcrc_pkg::*;

  logic        valid;
  logic        ready;
  crc_t        crc_value;
  logic [10:0] tag_out;

  modport source (output valid, crc_value, tag_out, input ready);
  modport sink (input valid, crc_value, tag_out, output ready);
endinterface

@@ rtl/link_packet_crc32k_generator.sv @@
// Link-packet CRC-32K generator: takes one header, data or tail word per
// transfer and returns the finished CRC and tag the cycle after each tail.
// Throughput is one word per cycle unless an unread result stalls input; the
// byte-cell chain folds a whole word in the cycle of its transfer. Synchronous
// reset sets the CRC register to all ones, clears the held header fields and
// empties the result register. Depends on lpcrc_pkg, lpcrc_if, lpcrc_chain.

module link_packet_crc32k_generator (
  input  logic                  clk,
  input  logic                  rst,
  lpcrc_item_if.sink            item,
  lpcrc_result_if.source        result
);
  import lpcrc_pkg::*;

  crc_t        running_crc;
  logic        response_mode;
  logic [2:0]  held_link;
  logic [10:0] held_tag;
  logic        out_valid;
  crc_t        out_crc;
  logic [10:0] out_tag;

  word_t       packed_word;
  crc_t        chain_in;
  crc_t        chain_out;
  logic        accept;
  logic        is_header;
  logic        is_data;
  logic        is_tail;

  assign item.ready = !out_valid || result.ready;
  assign accept     = item.valid && item.ready;
  assign is_header  = item.operation == OP_HEADER;
  assign is_data    = item.operation == OP_DATA;
  assign is_tail    = item.operation == OP_TAIL;

  always_comb begin
    packed_word = '0;
    if (is_header) begin
      packed_word[63:61] = item.cube_id;
      packed_word[22:12] = item.packet_tag;
      packed_word[11:7]  = item.flit_length;
      packed_word[6:0]   = item.command_code;
      if (item.is_response) begin
        packed_word[41:39] = item.source_link;
        packed_word[33]    = item.flag_bit;
      end else begin
        packed_word[57:24] = item.word_value[33:0];
      end
    end else if (is_tail) begin
      packed_word[31:29] = item.retry_count;
      packed_word[21]    = item.flag_bit;
      packed_word[20:0]  = item.pointers;
      if (response_mode) begin
        packed_word[28:22] = item.error_status;
      end else begin
        packed_word[28:26] = held_link;
      end
    end else begin
      packed_word = item.word_value;
    end
    chain_in = is_header ? CRC_INIT : running_crc;
  end

  lpcrc_chain u_chain (
    .crc_in  (chain_in),
    .word    (packed_word),
    .crc_out (chain_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc   <= CRC_INIT;
      response_mode <= 1'b0;
      held_link     <= '0;
      held_tag      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept && is_tail) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (is_header) begin
          running_crc   <= chain_out;
          response_mode <= item.is_response;
          held_link     <= item.source_link;
          held_tag      <= item.packet_tag;
        end else if (is_data) begin
          running_crc <= chain_out;
        end else if (is_tail) begin
          running_crc <= CRC_INIT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_tail) begin
      out_crc <= ~chain_out;
      out_tag <= held_tag;
    end
  end

  assign result.valid     = out_valid;
  assign result.crc_value = out_crc;
  assign result.tag_out   = out_tag;

endmodule

@@ rtl/lpcrc_byte_cell.sv @@
// One cell of the CRC chain: folds one byte into the reflected CRC-32K.
// Depends on lpcrc_pkg.

module lpcrc_byte_cell (
  input  lpcrc_pkg::crc_t  crc_in,
  input  lpcrc_pkg::byte_t data_byte,
  output lpcrc_pkg::crc_t  crc_out
);
  import lpcrc_pkg::*;

  always_comb begin
    crc_t c;
    c = crc_in ^ {{(CRC_WIDTH-BYTE_WIDTH){1'b0}}, data_byte};
    for (int k = 0; k < BYTE_WIDTH; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

@@ rtl/lpcrc_chain.sv @@
// Row of byte cells that folds a 64-bit word, least significant byte first.
// Depends on lpcrc_pkg and lpcrc_byte_cell.

module lpcrc_chain (
  input  lpcrc_pkg::crc_t  crc_in,
  input  lpcrc_pkg::word_t word,
  output lpcrc_pkg::crc_t  crc_out
);
  import lpcrc_pkg::*;

  crc_t link [0:CELL_COUNT];

  assign link[0] = crc_in;

  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    lpcrc_byte_cell u_cell (
      .crc_in    (link[i]),
      .data_byte (word[i*BYTE_WIDTH +: BYTE_WIDTH]),
      .crc_out   (link[i+1])
    );
  end

  assign crc_out = link[CELL_COUNT];

endmodule

@@ tb/lpcrc_checker.sv @@
// Checker for the link-packet CRC-32K generator: watches the word and result
// channels, predicts the CRC and tag of each packet and compares every result.
// Depends on lpcrc_pkg and the channel interfaces in lpcrc_if.

module lpcrc_checker (
  input  logic    clk,
  input  logic    rst,
  lpcrc_item_if   item,
  lpcrc_result_if result,
  output int      fail_count,
  output int      pending
);
  import lpcrc_pkg::*;

  typedef struct {
    crc_t        crc;
    logic [10:0] tag;
  } packet_crc_t;

  crc_t        crc_reg;
  logic        resp_mode;
  logic [2:0]  link_held;
  logic [10:0] tag_held;
  packet_crc_t crc_expect_q[$];

  function automatic crc_t crc32k_fold(input crc_t crc, input word_t w);
    crc_t c;
    c = crc;
    for (int b = 0; b < CELL_COUNT; b++) begin
      c ^= {24'd0, w[BYTE_WIDTH*b +: BYTE_WIDTH]};
      for (int k = 0; k < BYTE_WIDTH; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

  always @(posedge clk) begin
    word_t       w;
    packet_crc_t want;
    if (rst) begin
      crc_reg    = CRC_INIT;
      resp_mode  = 1'b0;
      link_held  = '0;
      tag_held   = '0;
      fail_count = 0;
      crc_expect_q.delete();
      pending <= 0;
    end else begin
      if (item.valid && item.ready) begin
        case (item.operation)
          OP_HEADER: begin
            resp_mode = item.is_response;
            link_held = item.source_link;
            tag_held  = item.packet_tag;
            w = '0;
            w[63:61] = item.cube_id;
            w[22:12] = item.packet_tag;
            w[11:7]  = item.flit_length;
            w[6:0]   = item.command_code;
            if (resp_mode) begin
              w[41:39] = item.source_link;
              w[33]    = item.flag_bit;
            end else begin
              w[57:24] = item.word_value[33:0];
            end
            crc_reg = crc32k_fold(CRC_INIT, w);
          end
          OP_DATA: begin
            crc_reg = crc32k_fold(crc_reg, item.word_value);
          end
          OP_TAIL: begin
            w = '0;
            w[31:29] = item.retry_count;
            w[21]    = item.flag_bit;
            w[20:0]  = item.pointers;
            if (resp_mode) begin
              w[28:22] = item.error_status;
            end else begin
              w[28:26] = link_held;
            end
            want.crc = crc32k_fold(crc_reg, w) ^ CRC_INIT;
            want.tag = tag_held;
            crc_expect_q.push_back(want);
            crc_reg = CRC_INIT;
          end
          default: begin
          end
        endcase
      end
      if (result.valid && result.ready) begin
        if (crc_expect_q.size() == 0) begin
          $error("Unexpected result transfer: crc_value %h, tag_out %h",
                 result.crc_value, result.tag_out);
          fail_count++;
        end else begin
          want = crc_expect_q.pop_front();
          if (result.crc_value !== want.crc) begin
            $error("crc_value mismatch: expected %h, actual %h", want.crc, result.crc_value);
            fail_count++;
          end
          if (result.tag_out !== want.tag) begin
            $error("tag_out mismatch: expected %h, actual %h", want.tag, result.tag_out);
            fail_count++;
          end
        end
      end
      pending <= crc_expect_q.size();
    end
  end

endmodule

@@ tb/link_packet_crc32k_generator_tb.sv @@
// Top of the testbench for the link-packet CRC-32K generator: clock, reset,
// packet stimulus, result back-pressure and the verdict.
// Depends on lpcrc_pkg, lpcrc_if, the generator RTL and lpcrc_checker.

module link_packet_crc32k_generator_tb;
  import lpcrc_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         ITEM_TARGET = 1700;
  localparam int         HOLD_CYCLES = 300;

  typedef struct {
    logic [1:0]  operation;
    logic        is_response;
    logic [2:0]  cube_id;
    logic [63:0] word_value;
    logic [10:0] packet_tag;
    logic [4:0]  flit_length;
    logic [6:0]  command_code;
    logic [2:0]  source_link;
    logic        flag_bit;
    logic [2:0]  retry_count;
    logic [6:0]  error_status;
    logic [20:0] pointers;
  } link_word_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycles;
  int   sent;
  bit   sender_burst;
  bit   receiver_burst;
  bit   hold_results;

  lpcrc_item_if   item_ch();
  lpcrc_result_if result_ch();

  link_packet_crc32k_generator DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  lpcrc_checker checker_inst (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic link_word_t random_word(input logic [1:0] op);
    link_word_t w;
    w.operation    = op;
    w.is_response  = 1'($urandom);
    w.cube_id      = 3'($urandom);
    w.word_value   = {$urandom, $urandom};
    w.packet_tag   = 11'($urandom);
    w.flit_length  = 5'($urandom);
    w.command_code = 7'($urandom);
    w.source_link  = 3'($urandom);
    w.flag_bit     = 1'($urandom);
    w.retry_count  = 3'($urandom);
    w.error_status = 7'($urandom);
    w.pointers     = 21'($urandom);
    return w;
  endfunction

  function automatic link_word_t extreme_word(input logic [1:0] op, input bit hi);
    link_word_t w;
    w.operation    = op;
    w.is_response  = hi;
    w.cube_id      = hi ? '1 : '0;
    w.word_value   = hi ? '1 : '0;
    w.packet_tag   = hi ? '1 : '0;
    w.flit_length  = hi ? '1 : '0;
    w.command_code = hi ? '1 : '0;
    w.source_link  = hi ? '1 : '0;
    w.flag_bit     = hi;
    w.retry_count  = hi ? '1 : '0;
    w.error_status = hi ? '1 : '0;
    w.pointers     = hi ? '1 : '0;
    return w;
  endfunction

  function automatic link_word_t mixed_word(input logic [1:0] op);
    return ($urandom_range(0, 15) == 0) ? extreme_word(op, 1'($urandom)) : random_word(op);
  endfunction

  task automatic send_word(input link_word_t w);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.operation    <= w.operation;
    item_ch.is_response  <= w.is_response;
    item_ch.cube_id      <= w.cube_id;
    item_ch.word_value   <= w.word_value;
    item_ch.packet_tag   <= w.packet_tag;
    item_ch.flit_length  <= w.flit_length;
    item_ch.command_code <= w.command_code;
    item_ch.source_link  <= w.source_link;
    item_ch.flag_bit     <= w.flag_bit;
    item_ch.retry_count  <= w.retry_count;
    item_ch.error_status <= w.error_status;
    item_ch.pointers     <= w.pointers;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (w.operation != OP_UNUSED) sent++;
  endtask

  task automatic send_packet(input int data_words);
    send_word(mixed_word(OP_HEADER));
    repeat (data_words) send_word(mixed_word(OP_DATA));
    send_word(mixed_word(OP_TAIL));
  endtask

  task automatic drain_results();
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int  hold_result_count;
    link_word_t w;
    cycles               = 0;
    sent                 = 0;
    sender_burst         = 1'b0;
    hold_results         = 1'b0;
    rst                  <= 1'b1;
    item_ch.valid        <= 1'b0;
    item_ch.operation    <= OP_HEADER;
    item_ch.is_response  <= 1'b0;
    item_ch.cube_id      <= '0;
    item_ch.word_value   <= '0;
    item_ch.packet_tag   <= '0;
    item_ch.flit_length  <= '0;
    item_ch.command_code <= '0;
    item_ch.source_link  <= '0;
    item_ch.flag_bit     <= 1'b0;
    item_ch.retry_count  <= '0;
    item_ch.error_status <= '0;
    item_ch.pointers     <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A tail and a data word with no header use the reset header fields.
    send_word(extreme_word(OP_TAIL, 1'b0));
    send_word(extreme_word(OP_DATA, 1'b1));
    send_word(extreme_word(OP_TAIL, 1'b1));
    w = extreme_word(OP_HEADER, 1'b1);
    w.is_response = 1'b0;
    send_word(w);
    send_word(extreme_word(OP_DATA, 1'b1));
    send_word(extreme_word(OP_DATA, 1'b0));
    send_word(extreme_word(OP_TAIL, 1'b1));
    send_word(extreme_word(OP_HEADER, 1'b1));
    send_word(extreme_word(OP_TAIL, 1'b1));
    send_word(extreme_word(OP_HEADER, 1'b0));
    send_word(extreme_word(OP_TAIL, 1'b0));
    w = extreme_word(OP_HEADER, 1'b0);
    w.is_response = 1'b1;
    send_word(w);
    send_word(extreme_word(OP_TAIL, 1'b0));
    // A second header in the middle of a packet restarts the CRC.
    send_word(random_word(OP_HEADER));
    send_word(random_word(OP_DATA));
    w = random_word(OP_HEADER);
    w.is_response = ~w.is_response;
    send_word(w);
    send_word(random_word(OP_DATA));
    send_word(random_word(OP_TAIL));
    send_word(random_word(OP_UNUSED));
    send_word(random_word(OP_HEADER));
    send_word(random_word(OP_UNUSED));
    send_word(random_word(OP_DATA));
    send_word(random_word(OP_UNUSED));
    send_word(random_word(OP_TAIL));
    send_word(random_word(OP_TAIL));

    while (sent < ITEM_TARGET) begin
      sender_burst = ($urandom_range(0, 3) == 0);
      if (sent > 600 && hold_result_count == 0) begin
        hold_result_count = 1;
        hold_results = 1'b1;
        sender_burst = 1'b1;
        repeat (40) send_packet(0);
      end else if (sent > 1100 && hold_result_count == 1) begin
        hold_result_count = 2;
        item_ch.valid <= 1'b0;
        drain_results();
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send_word(mixed_word(2'($urandom_range(0, 3))));
      end else begin
        send_packet(($urandom_range(0, 9) == 0) ? $urandom_range(5, 20)
                                                 : $urandom_range(0, 3));
      end
    end

    item_ch.valid <= 1'b0;
    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int stall;
    receiver_burst  = 1'b0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) receiver_burst = ~receiver_burst;
      if (hold_results) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        stall = receiver_burst ? 0 : $urandom_range(0, 18);
        if (stall > 0) begin
          result_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

endmodule
